// ----- rtl/hvi_pkg.sv -----
// Shared constants and types for the HSV value inversion block.
`default_nettype none

package hvi_pkg;

    // Default internal channel precision.
    localparam int CHANNEL_BITS_DEFAULT = 16;

    // Width of every color and alpha field on the stream ports.
    localparam int FIELD_BITS = 16;

    // Stream data width: red, green, blue and alpha packed from the lowest bit up.
    localparam int TDATA_BITS = 4 * FIELD_BITS;

    // Fields that ride alongside the arithmetic pipeline unchanged.
    typedef struct packed {
        logic [FIELD_BITS-1:0] alpha;
        logic                  last;
    } side_t;

endpackage

`default_nettype wire

// ----- rtl/hvi_front.sv -----
// Front end of the pipeline: clamp, maximum search, inverse value and products.
`default_nettype none

module hvi_front
    import hvi_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [FIELD_BITS-1:0]       red_in,
    input  wire logic [FIELD_BITS-1:0]       green_in,
    input  wire logic [FIELD_BITS-1:0]       blue_in,
    output logic      [CHANNEL_BITS-1:0]     value_out,
    output logic      [2*CHANNEL_BITS-1:0]   prod_red,
    output logic      [2*CHANNEL_BITS-1:0]   prod_green,
    output logic      [2*CHANNEL_BITS-1:0]   prod_blue
);

    localparam int WIDE = (CHANNEL_BITS > FIELD_BITS) ? CHANNEL_BITS : FIELD_BITS;
    localparam logic [CHANNEL_BITS-1:0] FULL_SCALE = {CHANNEL_BITS{1'b1}};
    localparam logic [WIDE-1:0] FULL_SCALE_WIDE = WIDE'(FULL_SCALE);

    logic [WIDE-1:0]           red_wide, green_wide, blue_wide;
    logic [CHANNEL_BITS-1:0]   red_next, green_next, blue_next, max_next;
    logic [CHANNEL_BITS-1:0]   red_reg, green_reg, blue_reg, max_reg;
    logic [CHANNEL_BITS-1:0]   inv;
    logic [2*CHANNEL_BITS-1:0] prod_red_next, prod_green_next, prod_blue_next;
    logic [2*CHANNEL_BITS-1:0] prod_red_reg, prod_green_reg, prod_blue_reg;
    logic [CHANNEL_BITS-1:0]   value_reg;

    // Saturate each color to full scale and find the largest one.
    always_comb begin
        red_wide   = WIDE'(red_in);
        green_wide = WIDE'(green_in);
        blue_wide  = WIDE'(blue_in);
        red_next   = (red_wide > FULL_SCALE_WIDE) ? FULL_SCALE : red_wide[CHANNEL_BITS-1:0];
        green_next = (green_wide > FULL_SCALE_WIDE) ? FULL_SCALE : green_wide[CHANNEL_BITS-1:0];
        blue_next  = (blue_wide > FULL_SCALE_WIDE) ? FULL_SCALE : blue_wide[CHANNEL_BITS-1:0];
        max_next   = red_next;
        if (green_next > max_next) begin
            max_next = green_next;
        end
        if (blue_next > max_next) begin
            max_next = blue_next;
        end
    end

    // First stage register.
    always_ff @(posedge aclk) begin
        if (en) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            max_reg   <= max_next;
        end
    end

    // Inverted value times each color. The maximum channel later divides back to
    // exactly the inverted value, and a black pixel divides by zero to full scale.
    always_comb begin
        inv             = FULL_SCALE - max_reg;
        prod_red_next   = (2*CHANNEL_BITS)'(inv) * (2*CHANNEL_BITS)'(red_reg);
        prod_green_next = (2*CHANNEL_BITS)'(inv) * (2*CHANNEL_BITS)'(green_reg);
        prod_blue_next  = (2*CHANNEL_BITS)'(inv) * (2*CHANNEL_BITS)'(blue_reg);
    end

    // Second stage register.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_red_reg   <= prod_red_next;
            prod_green_reg <= prod_green_next;
            prod_blue_reg  <= prod_blue_next;
            value_reg      <= max_reg;
        end
    end

    assign value_out  = value_reg;
    assign prod_red   = prod_red_reg;
    assign prod_green = prod_green_reg;
    assign prod_blue  = prod_blue_reg;

endmodule

`default_nettype wire

// ----- rtl/hvi_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module hvi_div
    import hvi_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEFAULT
) (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [2*CHANNEL_BITS-1:0]   dividend,
    input  wire logic [CHANNEL_BITS-1:0]     divisor,
    output logic      [CHANNEL_BITS-1:0]     quotient
);

    // The dividend is below divisor times 2^CHANNEL_BITS, so its upper half starts
    // as a remainder smaller than the divisor and only the lower half needs steps.
    // With a zero divisor every trial succeeds and the quotient is all ones.
    logic [CHANNEL_BITS-1:0] rem_reg  [CHANNEL_BITS];
    logic [CHANNEL_BITS-1:0] word_reg [CHANNEL_BITS];
    logic [CHANNEL_BITS-1:0] dsr_reg  [CHANNEL_BITS];
    logic [CHANNEL_BITS-1:0] rem_next [CHANNEL_BITS];
    logic [CHANNEL_BITS-1:0] word_next[CHANNEL_BITS];

    for (genvar s = 0; s < CHANNEL_BITS; s++) begin : g_step
        logic [CHANNEL_BITS-1:0] rem_in, word_in, dsr_in;
        logic [CHANNEL_BITS:0]   trial;
        logic                    take;

        if (s == 0) begin : g_first
            assign rem_in  = dividend[2*CHANNEL_BITS-1:CHANNEL_BITS];
            assign word_in = dividend[CHANNEL_BITS-1:0];
            assign dsr_in  = divisor;
        end else begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign word_in = word_reg[s-1];
            assign dsr_in  = dsr_reg[s-1];
        end

        // Shift in the next dividend bit and try to subtract the divisor.
        // The word register shifts dividend bits out at the top and quotient bits in.
        always_comb begin
            trial        = {rem_in, word_in[CHANNEL_BITS-1]};
            take         = trial >= {1'b0, dsr_in};
            rem_next[s]  = take ? CHANNEL_BITS'(trial - {1'b0, dsr_in})
                                : trial[CHANNEL_BITS-1:0];
            word_next[s] = {word_in[CHANNEL_BITS-2:0], take};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s]  <= rem_next[s];
                word_reg[s] <= word_next[s];
                dsr_reg[s]  <= dsr_in;
            end
        end
    end

    assign quotient = word_reg[CHANNEL_BITS-1];

endmodule

`default_nettype wire

// ----- rtl/hsv_value_invert.sv -----
// Top level of the HSV value inversion block: stream ports and pipeline control.
//
//  Channel | Direction | Ports                       | Transaction
//  --------+-----------+-----------------------------+---------------------------
//  s_      | in        | s_tvalid s_tready s_tdata   | one RGBA pixel, tlast marks
//          |           | s_tlast                     | the final pixel of a run
//  m_      | out       | m_tvalid m_tready m_tdata   | one inverted RGBA pixel
//          |           | m_tlast                     |
//
// A pixel passes through two front stages (clamp and maximum, then multiply)
// and one divider stage per quotient bit on its way from input to output.
// One pixel enters and one leaves every cycle while the output is taken.
// Reset clears only the valid bits of the pipeline.
// When a result waits at the output and m_tready is low, the whole pipeline
// holds and s_tready drops, even if there are bubbles further up the pipeline.
`default_nettype none

module hsv_value_invert
    import hvi_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [TDATA_BITS-1:0] s_tdata,   // red_in, green_in, blue_in, alpha_in
    input  wire logic                  s_tlast,   // last_pixel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [TDATA_BITS-1:0] m_tdata,   // red_out, green_out, blue_out, alpha_out
    output logic                       m_tlast    // last_pixel_out
);

    localparam int LATENCY = CHANNEL_BITS + 2;

    logic                        advance;
    logic [LATENCY-1:0]          valid_reg, valid_next;
    side_t                       side_reg [LATENCY];
    side_t                       side_in;
    logic [CHANNEL_BITS-1:0]     value;
    logic [2*CHANNEL_BITS-1:0]   prod_red, prod_green, prod_blue;
    logic [CHANNEL_BITS-1:0]     q_red, q_green, q_blue;

    // The pipeline moves whenever the output stage is empty or being taken.
    assign advance    = !valid_reg[LATENCY-1] || m_tready;
    assign s_tready   = advance;
    assign valid_next = {valid_reg[LATENCY-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    // Alpha and the last marker ride along in a delay line.
    assign side_in.alpha = s_tdata[4*FIELD_BITS-1:3*FIELD_BITS];
    assign side_in.last  = s_tlast;

    for (genvar i = 0; i < LATENCY; i++) begin : g_side
        always_ff @(posedge aclk) begin
            if (advance) begin
                if (i == 0) begin
                    side_reg[i] <= side_in;
                end else begin
                    side_reg[i] <= side_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    hvi_front #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_front (
        .aclk      (aclk),
        .en        (advance),
        .red_in    (s_tdata[FIELD_BITS-1:0]),
        .green_in  (s_tdata[2*FIELD_BITS-1:FIELD_BITS]),
        .blue_in   (s_tdata[3*FIELD_BITS-1:2*FIELD_BITS]),
        .value_out (value),
        .prod_red  (prod_red),
        .prod_green(prod_green),
        .prod_blue (prod_blue)
    );

    hvi_div #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_div_red (
        .aclk    (aclk),
        .en      (advance),
        .dividend(prod_red),
        .divisor (value),
        .quotient(q_red)
    );

    hvi_div #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_div_green (
        .aclk    (aclk),
        .en      (advance),
        .dividend(prod_green),
        .divisor (value),
        .quotient(q_green)
    );

    hvi_div #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_div_blue (
        .aclk    (aclk),
        .en      (advance),
        .dividend(prod_blue),
        .divisor (value),
        .quotient(q_blue)
    );

    // Output fields keep the low bits of each quotient.
    assign m_tvalid = valid_reg[LATENCY-1];
    assign m_tdata  = {side_reg[LATENCY-1].alpha,
                       FIELD_BITS'(q_blue),
                       FIELD_BITS'(q_green),
                       FIELD_BITS'(q_red)};
    assign m_tlast  = side_reg[LATENCY-1].last;

    // A result held at the output blocks new input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output stalled");

    // An accepted pixel occupies the first pipeline slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted pixel lost at pipeline entry");

    // Reset empties the pipeline.
    assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && (valid_reg == '0)))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
